// ----- rtl/msec_pkg.sv -----
package msec_pkg;

  // Memory request codes
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SPECIAL = 3'd1,
    ST_BAD_REGIMM  = 3'd2,
    ST_BAD_OPCODE  = 3'd3,
    ST_WRONG_KIND  = 3'd4
  } status_e;

  // Item kinds
  localparam logic KIND_INSTR = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0]  REG_ZERO    = 5'd0;
  localparam logic [4:0]  REG_LINK    = 5'd31;
  localparam logic [31:0] JUMP_REGION = 32'h1E00_0000;

  // Modeled cycle costs
  localparam logic [2:0] COST_NONE  = 3'd0;
  localparam logic [2:0] COST_BASIC = 3'd3;
  localparam logic [2:0] COST_CMP   = 3'd4;
  localparam logic [2:0] COST_BR    = 3'd5;
  localparam logic [2:0] COST_LONG  = 3'd6;

  // Register file write port
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
  } wr_t;

  // One result item
  typedef struct packed {
    logic [31:0] next_pc;
    mem_op_e     mem_op;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [31:0] cycle_total;
    status_e     status;
  } res_t;

  // Core state carried between items
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] cycles;
    logic        ld_pend;
    logic [4:0]  ld_tgt;
  } core_st_t;

endpackage

// ----- rtl/msec_regfile.sv -----
module msec_regfile (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [4:0]        ra_a_i,
  input  logic [4:0]        ra_b_i,
  input  msec_pkg::wr_t     wr_i,
  output logic [31:0]       rd_a_o,
  output logic [31:0]       rd_b_o
);

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] raw_a_q, raw_b_q, byp_data_q;
  logic        vld_a_q, vld_b_q, byp_a_q, byp_b_q;

  // Write port; r0 is never written so it keeps reading zero
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.addr != msec_pkg::REG_ZERO)) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Per-entry written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we && (wr_i.addr != msec_pkg::REG_ZERO)) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Registered reads, with bypass of a same-edge write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raw_a_q    <= mem[ra_a_i];
      raw_b_q    <= mem[ra_b_i];
      vld_a_q    <= vld_q[ra_a_i];
      vld_b_q    <= vld_q[ra_b_i];
      byp_a_q    <= wr_i.we && (wr_i.addr == ra_a_i) && (ra_a_i != msec_pkg::REG_ZERO);
      byp_b_q    <= wr_i.we && (wr_i.addr == ra_b_i) && (ra_b_i != msec_pkg::REG_ZERO);
      byp_data_q <= wr_i.data;
    end
  end

  assign rd_a_o = byp_a_q ? byp_data_q : (vld_a_q ? raw_a_q : '0);
  assign rd_b_o = byp_b_q ? byp_data_q : (vld_b_q ? raw_b_q : '0);

endmodule

// ----- rtl/msec_exec.sv -----
module msec_exec (
  input  logic                kind_i,
  input  logic [31:0]         instr_i,
  input  logic [31:0]         ldata_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  msec_pkg::core_st_t  st_i,
  output msec_pkg::core_st_t  st_o,
  output msec_pkg::wr_t       wr_o,
  output msec_pkg::res_t      res_o
);

  logic [5:0]  opcode, func;
  logic [4:0]  shamt, rd, rt, rs;
  logic [31:0] simm, imm, seq, btarget, jtarget, addr_sum;
  logic [2:0]  cost;
  logic        neg;
  logic [31:0] next_pc;
  msec_pkg::wr_t     wr;
  msec_pkg::mem_op_e mem_op;
  msec_pkg::status_e status;
  logic [31:0] mem_addr, mem_wdata;
  logic        ld_pend_d;
  logic [4:0]  ld_tgt_d;

  // Field decode and shared adders
  assign opcode   = instr_i[31:26];
  assign rs       = instr_i[25:21];
  assign rt       = instr_i[20:16];
  assign rd       = instr_i[15:11];
  assign shamt    = instr_i[10:6];
  assign func     = instr_i[5:0];
  assign simm     = {{16{instr_i[15]}}, instr_i[15:0]};
  assign imm      = {16'h0000, instr_i[15:0]};
  assign seq      = st_i.pc + 32'd4;
  assign btarget  = seq + {simm[29:0], 2'b00};
  assign jtarget  = (seq & msec_pkg::JUMP_REGION) | {4'h0, instr_i[25:0], 2'b00};
  assign addr_sum = a_i + simm;
  assign neg      = a_i[31];

  // Instruction execute
  always_comb begin
    next_pc   = st_i.pc;
    mem_op    = msec_pkg::MEM_NONE;
    mem_addr  = '0;
    mem_wdata = '0;
    status    = msec_pkg::ST_OK;
    cost      = msec_pkg::COST_NONE;
    wr.we     = 1'b0;
    wr.addr   = rd;
    wr.data   = '0;
    ld_pend_d = st_i.ld_pend;
    ld_tgt_d  = st_i.ld_tgt;

    if ((kind_i == msec_pkg::KIND_LOAD) || st_i.ld_pend) begin
      if ((kind_i == msec_pkg::KIND_LOAD) && st_i.ld_pend) begin
        wr.we     = 1'b1;
        wr.addr   = st_i.ld_tgt;
        wr.data   = ldata_i;
        ld_pend_d = 1'b0;
      end else begin
        status = msec_pkg::ST_WRONG_KIND;
      end
    end else begin
      next_pc = seq;
      unique case (opcode)
        msec_pkg::OP_SPECIAL: begin
          cost  = msec_pkg::COST_BASIC;
          wr.we = 1'b1;
          unique case (func)
            msec_pkg::FN_SLL:  wr.data = b_i << shamt;
            msec_pkg::FN_SRL:  wr.data = b_i >> shamt;
            msec_pkg::FN_SRA:  wr.data = 32'($signed(b_i) >>> shamt);
            msec_pkg::FN_SLLV: wr.data = b_i << a_i[4:0];
            msec_pkg::FN_SRLV: wr.data = b_i >> a_i[4:0];
            msec_pkg::FN_SRAV: wr.data = 32'($signed(b_i) >>> a_i[4:0]);
            msec_pkg::FN_JR: begin
              wr.we   = 1'b0;
              next_pc = a_i;
              cost    = msec_pkg::COST_CMP;
            end
            msec_pkg::FN_JALR: begin
              wr.addr = msec_pkg::REG_LINK;
              wr.data = seq;
              next_pc = a_i;
              cost    = msec_pkg::COST_BR;
            end
            msec_pkg::FN_ADD, msec_pkg::FN_ADDU: wr.data = a_i + b_i;
            msec_pkg::FN_SUB, msec_pkg::FN_SUBU: wr.data = a_i - b_i;
            msec_pkg::FN_AND: wr.data = a_i & b_i;
            msec_pkg::FN_OR:  wr.data = a_i | b_i;
            msec_pkg::FN_XOR: wr.data = a_i ^ b_i;
            msec_pkg::FN_NOR: wr.data = ~(a_i | b_i);
            msec_pkg::FN_SLT: begin
              wr.data = {31'd0, $signed(a_i) < $signed(b_i)};
              cost    = msec_pkg::COST_CMP;
            end
            msec_pkg::FN_SLTU: begin
              wr.data = {31'd0, a_i < b_i};
              cost    = msec_pkg::COST_CMP;
            end
            default: begin
              wr.we  = 1'b0;
              status = msec_pkg::ST_BAD_SPECIAL;
              cost   = msec_pkg::COST_NONE;
            end
          endcase
        end
        msec_pkg::OP_REGIMM: begin
          wr.addr = msec_pkg::REG_LINK;
          wr.data = seq;
          unique case (rt)
            msec_pkg::RI_BLTZAL: begin
              wr.we = 1'b1;
              if (neg) next_pc = btarget;
              cost = msec_pkg::COST_LONG;
            end
            msec_pkg::RI_BLTZ: begin
              if (neg) next_pc = btarget;
              cost = msec_pkg::COST_BR;
            end
            msec_pkg::RI_BGEZAL: begin
              wr.we = 1'b1;
              if (!neg) next_pc = btarget;
              cost = msec_pkg::COST_LONG;
            end
            msec_pkg::RI_BGEZ: begin
              if (!neg) next_pc = btarget;
              cost = msec_pkg::COST_BR;
            end
            default: status = msec_pkg::ST_BAD_REGIMM;
          endcase
        end
        msec_pkg::OP_J: begin
          next_pc = jtarget;
          cost    = msec_pkg::COST_CMP;
        end
        msec_pkg::OP_JAL: begin
          wr.we   = 1'b1;
          wr.addr = msec_pkg::REG_LINK;
          wr.data = seq;
          next_pc = jtarget;
          cost    = msec_pkg::COST_BR;
        end
        msec_pkg::OP_BEQ: begin
          if (a_i == b_i) next_pc = btarget;
          cost = msec_pkg::COST_BR;
        end
        msec_pkg::OP_BNE: begin
          if (a_i != b_i) next_pc = btarget;
          cost = msec_pkg::COST_BR;
        end
        msec_pkg::OP_BLEZ: begin
          if ($signed(a_i) < $signed(32'sd1)) next_pc = btarget;
          cost = msec_pkg::COST_BR;
        end
        msec_pkg::OP_BGTZ: begin
          if (!($signed(a_i) < $signed(32'sd1))) next_pc = btarget;
          cost = msec_pkg::COST_BR;
        end
        msec_pkg::OP_ADDI, msec_pkg::OP_ADDIU: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = addr_sum;
          cost    = msec_pkg::COST_BASIC;
        end
        msec_pkg::OP_SLTI: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = {31'd0, $signed(a_i) < $signed(simm)};
          cost    = msec_pkg::COST_CMP;
        end
        msec_pkg::OP_SLTIU: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = {31'd0, a_i < simm};
          cost    = msec_pkg::COST_CMP;
        end
        msec_pkg::OP_ANDI: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = a_i & imm;
          cost    = msec_pkg::COST_BASIC;
        end
        msec_pkg::OP_ORI: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = a_i | imm;
          cost    = msec_pkg::COST_BASIC;
        end
        msec_pkg::OP_XORI: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = a_i ^ imm;
          cost    = msec_pkg::COST_BASIC;
        end
        msec_pkg::OP_LUI: begin
          wr.we   = 1'b1;
          wr.addr = rt;
          wr.data = {instr_i[15:0], 16'h0000};
          cost    = msec_pkg::COST_BASIC;
        end
        msec_pkg::OP_LW: begin
          mem_op    = msec_pkg::MEM_READ;
          mem_addr  = addr_sum;
          ld_pend_d = 1'b1;
          ld_tgt_d  = rt;
          cost      = msec_pkg::COST_LONG;
        end
        msec_pkg::OP_SW: begin
          mem_op    = msec_pkg::MEM_WRITE;
          mem_addr  = addr_sum;
          mem_wdata = b_i;
          cost      = msec_pkg::COST_LONG;
        end
        default: status = msec_pkg::ST_BAD_OPCODE;
      endcase
    end

    // writes to r0 are dropped
    if (wr.addr == msec_pkg::REG_ZERO) wr.we = 1'b0;
  end

  assign wr_o = wr;

  assign st_o.pc      = next_pc;
  assign st_o.cycles  = st_i.cycles + {29'd0, cost};
  assign st_o.ld_pend = ld_pend_d;
  assign st_o.ld_tgt  = ld_tgt_d;

  assign res_o.next_pc        = next_pc;
  assign res_o.mem_op         = mem_op;
  assign res_o.mem_address    = mem_addr;
  assign res_o.mem_write_data = mem_wdata;
  assign res_o.cycle_total    = st_o.cycles;
  assign res_o.status         = status;

endmodule

// ----- rtl/mips_subset_execute_core.sv -----
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o | kind_i, instruction_word_i, load_data_i
// out     | output    | out_valid_o / out_stall_i | next_pc_o, mem_op_o, mem_address_o,
//         |           |                        | mem_write_data_o, cycle_total_o, status_o
//
// The input transfer loads the item and its two register file reads into stage 1;
// when stage 1 advances, the item is executed into the result register. One item
// per cycle is sustained while out_stall_i is low; the register file bypass covers an
// item that reads what the previous one writes. Reset is asynchronous and clears
// pc, cycle total, pending-load mark and the register file written flags, so all
// registers read zero. An output stall holds the result and backs up to in_stall_o.
module mips_subset_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] instruction_word_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_op_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_write_data_o,
  output logic [31:0] cycle_total_o,
  output logic [2:0]  status_o
);

  logic               s1_valid_q, s1_kind_q;
  logic [31:0]        s1_instr_q, s1_ldata_q;
  logic               out_valid_q;
  logic               in_fire, s1_adv, s1_fire;
  logic [31:0]        rd_a, rd_b;
  msec_pkg::core_st_t st_q, st_d;
  msec_pkg::wr_t      wr;
  msec_pkg::wr_t      wr_raw;
  msec_pkg::res_t     res_d, res_q;

  // Flow control: stage 1 moves when the result register is free or draining
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= kind_i;
      s1_instr_q <= instruction_word_i;
      s1_ldata_q <= load_data_i;
    end
  end

  // Register file, read at input transfer
  msec_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_fire),
    .ra_a_i  (instruction_word_i[25:21]),
    .ra_b_i  (instruction_word_i[20:16]),
    .wr_i    (wr),
    .rd_a_o  (rd_a),
    .rd_b_o  (rd_b)
  );

  msec_exec u_exec (
    .kind_i  (s1_kind_q),
    .instr_i (s1_instr_q),
    .ldata_i (s1_ldata_q),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .st_i    (st_q),
    .st_o    (st_d),
    .wr_o    (wr_raw),
    .res_o   (res_d)
  );

  // Commit only when the item leaves stage 1
  always_comb begin
    wr    = wr_raw;
    wr.we = wr_raw.we && s1_fire;
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_pc_o        = res_q.next_pc;
  assign mem_op_o         = res_q.mem_op;
  assign mem_address_o    = res_q.mem_address;
  assign mem_write_data_o = res_q.mem_write_data;
  assign cycle_total_o    = res_q.cycle_total;
  assign status_o         = res_q.status;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty stage");

  a_load_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (res_d.mem_op == msec_pkg::MEM_READ)) |=> st_q.ld_pend)
    else $error("load issued without pending mark");

  a_pending_blocks_instr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && st_q.ld_pend && (s1_kind_q == msec_pkg::KIND_INSTR)) |->
    (res_d.status == msec_pkg::ST_WRONG_KIND))
    else $error("instruction executed while load pending");

  a_wrong_kind_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (res_d.status == msec_pkg::ST_WRONG_KIND)) |->
    (!wr.we && (st_d == st_q)))
    else $error("wrong item kind changed state");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (wr.addr != msec_pkg::REG_ZERO))
    else $error("write to r0");

endmodule
